### src/glucose_alarm_snooze_controller_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the glucose alarm snooze controller checkers.
// The enclosing module must have aclk and aresetn in scope.
// ----------------------------------------------------------------------------
`ifndef GLUCOSE_ALARM_SNOOZE_CONTROLLER_ASSERT_SVH
`define GLUCOSE_ALARM_SNOOZE_CONTROLLER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GASC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GASC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/gasc_pkg.sv
// ----------------------------------------------------------------------------
// gasc_pkg
// Types, codes and helper functions shared by the glucose alarm controller.
// ----------------------------------------------------------------------------
`default_nettype none

package gasc_pkg;

    // Number of alert windows looked at per level, and their packing.
    localparam int WINDOWS_PER_LEVEL = 2;
    localparam int WIN_BITS          = 30;
    localparam int WIN_FIELD_BITS    = 60;

    // Top of the high range in mg/dl.
    localparam logic [8:0] HIGH_CEILING_MGDL = 9'd401;

    // Repeat period in intensive mode, seconds.
    localparam logic [15:0] INTENSIVE_SECONDS = 16'd2;

    // Seconds per minute.
    localparam logic [5:0] SECS_PER_MIN = 6'd60;

    // Level codes.
    localparam logic [1:0] LVL_URGENT = 2'd0;
    localparam logic [1:0] LVL_LOW    = 2'd1;
    localparam logic [1:0] LVL_HIGH   = 2'd2;
    localparam logic [1:0] LVL_NONE   = 2'd3;

    // Action codes.
    localparam logic ACT_TICK   = 1'b0;
    localparam logic ACT_SNOOZE = 1'b1;

    // Configuration register indexes.
    localparam logic [2:0] CFG_ENABLES    = 3'd0;
    localparam logic [2:0] CFG_THRESHOLDS = 3'd1;
    localparam logic [2:0] CFG_SNOOZE     = 3'd2;
    localparam logic [2:0] CFG_REPEAT     = 3'd3;
    localparam logic [2:0] CFG_STALE      = 3'd4;
    localparam logic [2:0] CFG_WIN_URGENT = 3'd5;
    localparam logic [2:0] CFG_WIN_LOW    = 3'd6;
    localparam logic [2:0] CFG_WIN_HIGH   = 3'd7;

    // Input beat.
    typedef struct packed {
        logic        action;
        logic        reading_present;
        logic [8:0]  glucose_mgdl;
        logic [23:0] reading_age_seconds;
        logic [31:0] now_epoch_seconds;
        logic        clock_known;
        logic [2:0]  weekday;
        logic [10:0] minute_of_day;
    } in_t;

    // Result beat.
    typedef struct packed {
        logic       play_sound;
        logic [1:0] sound_level;
        logic [1:0] active_level;
        logic       active_snoozed;
    } out_t;

    // True when the level's windows let an alarm through at this day and minute.
    // No valid window, or an unknown clock, lets everything through. A window
    // whose start is not below its end wraps past midnight into the next day.
    function automatic logic window_allows(
        input logic [WIN_FIELD_BITS-1:0] packed_w,
        input logic                      clk_ok,
        input logic [2:0]                day,
        input logic [2:0]                yday,
        input logic [10:0]               minute
    );
        logic          any_valid;
        logic          hit;
        logic [29:0]   win;
        logic [10:0]   end_m;
        logic [10:0]   start_m;
        logic [6:0]    days;
        any_valid = 1'b0;
        hit       = 1'b0;
        for (int w = 0; w < WINDOWS_PER_LEVEL; w++) begin
            win     = packed_w[w*WIN_BITS +: WIN_BITS];
            end_m   = win[10:0];
            start_m = win[21:11];
            days    = win[28:22];
            if (win[29]) begin
                any_valid = 1'b1;
                if (start_m < end_m) begin
                    if (days[day] && minute >= start_m && minute < end_m) begin
                        hit = 1'b1;
                    end
                end else begin
                    if (days[day] && minute >= start_m) begin
                        hit = 1'b1;
                    end
                    if (days[yday] && minute < end_m) begin
                        hit = 1'b1;
                    end
                end
            end
        end
        return !any_valid || !clk_ok || hit;
    endfunction

endpackage

`default_nettype wire

### src/glucose_alarm_snooze_controller.sv
// ----------------------------------------------------------------------------
// glucose_alarm_snooze_controller
// Three-level glucose alarm controller with weekday/time windows, repeat and
// snooze handling. One result beat per input beat.
// ----------------------------------------------------------------------------
// The block takes one input beat per clock cycle while m_ready stays high and
// returns exactly one result beat for each, in order. An accepted beat is
// held in the input register, where all level, window and timer checks are
// done in a single pass. Its result is loaded into the output register when
// that register is empty or its beat is being taken, and m_valid then rises.
// The sustained rate is one beat per cycle for as long as m_ready stays high.
// While a finished result waits with m_ready low, one more beat is taken
// into the input register, and s_ready then stays low until the waiting
// result leaves. Configuration writes are always accepted (cfg_ready is tied
// high) and take effect on the next beat processed; they are meant to be
// issued only while no beat is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module glucose_alarm_snooze_controller
    import gasc_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    // Input channel
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire in_t                       s_data,
    // Result channel
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output out_t                           m_data,
    // Configuration write channel
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [2:0]                cfg_index,
    input  wire logic [WIN_FIELD_BITS-1:0] cfg_data
);

    // Configuration registers
    logic [3:0]                enables_reg;
    logic [26:0]               thresholds_reg;
    logic [23:0]               snooze_reg;
    logic [15:0]               repeat_reg;
    logic [9:0]                stale_reg;
    logic [WIN_FIELD_BITS-1:0] windows_reg [3];

    // Alarm state
    logic        active_valid_reg, active_valid_next;
    logic [1:0]  active_index_reg, active_index_next;
    logic [31:0] last_time_reg [3];
    logic [31:0] last_time_next [3];
    logic [2:0]  snoozed_reg, snoozed_next;

    // Pipeline registers
    logic  in_valid_reg;
    in_t   in_data_reg;
    logic  m_valid_reg;
    out_t  m_data_reg;
    out_t  result;

    logic advance;

    // Decoded operands
    logic [8:0]  t_urg, t_low, t_high;
    logic [2:0]  day, yday;
    logic [15:0] stale_secs;
    logic        stale;
    logic [2:0]  in_range;
    logic [2:0]  level_hit;
    logic [2:0]  allow;
    logic        hit_any;
    logic [1:0]  hit_lvl;
    logic        hit_allow;
    logic [31:0] diff;
    logic [7:0]  snz_min;
    logic [13:0] snz_secs;
    logic [15:0] interval;
    logic        play;
    logic [1:0]  sound;

    // Handshakes
    assign advance   = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign cfg_ready = 1'b1;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enables_reg    <= '0;
            thresholds_reg <= '0;
            snooze_reg     <= '0;
            repeat_reg     <= 16'd60;
            stale_reg      <= 10'd15;
            for (int i = 0; i < 3; i++) begin
                windows_reg[i] <= '0;
            end
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_ENABLES:    enables_reg    <= cfg_data[3:0];
                CFG_THRESHOLDS: thresholds_reg <= cfg_data[26:0];
                CFG_SNOOZE:     snooze_reg     <= cfg_data[23:0];
                CFG_REPEAT:     repeat_reg     <= cfg_data[15:0];
                CFG_STALE:      stale_reg      <= cfg_data[9:0];
                CFG_WIN_URGENT: windows_reg[0] <= cfg_data;
                CFG_WIN_LOW:    windows_reg[1] <= cfg_data;
                CFG_WIN_HIGH:   windows_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // Level ranges, staleness and the clock of this beat.
    always_comb begin
        t_urg  = thresholds_reg[8:0];
        t_low  = thresholds_reg[17:9];
        t_high = thresholds_reg[26:18];
        day    = (in_data_reg.weekday > 3'd6) ? 3'd0 : in_data_reg.weekday;
        yday   = (day == 3'd0) ? 3'd6 : day - 3'd1;
        stale_secs = 16'(stale_reg * SECS_PER_MIN);
        stale  = {8'd0, in_data_reg.reading_age_seconds} > {16'd0, stale_secs};
        in_range[0] = in_data_reg.glucose_mgdl >= 9'd1 &&
                      in_data_reg.glucose_mgdl <= t_urg;
        in_range[1] = in_data_reg.glucose_mgdl > t_urg &&
                      in_data_reg.glucose_mgdl < t_low;
        in_range[2] = in_data_reg.glucose_mgdl >= t_high &&
                      in_data_reg.glucose_mgdl <= HIGH_CEILING_MGDL;
        level_hit = in_range & enables_reg[2:0];
        for (int l = 0; l < 3; l++) begin
            allow[l] = window_allows(windows_reg[l], in_data_reg.clock_known, day, yday,
                                     in_data_reg.minute_of_day);
        end
    end

    // First enabled level that holds the reading.
    always_comb begin
        hit_any = |level_hit;
        if (level_hit[0]) begin
            hit_lvl = LVL_URGENT;
        end else if (level_hit[1]) begin
            hit_lvl = LVL_LOW;
        end else begin
            hit_lvl = LVL_HIGH;
        end
        hit_allow = allow[hit_lvl];
    end

    // Timers of the active alarm, whatever level the reading is in now.
    always_comb begin
        diff     = in_data_reg.now_epoch_seconds - last_time_reg[active_index_reg];
        snz_min  = snooze_reg[active_index_reg*8 +: 8];
        snz_secs = 14'(snz_min * SECS_PER_MIN);
        interval = enables_reg[3] ? INTENSIVE_SECONDS : repeat_reg;
    end

    // Alarm state update and result.
    always_comb begin
        active_valid_next = active_valid_reg;
        active_index_next = active_index_reg;
        snoozed_next      = snoozed_reg;
        for (int i = 0; i < 3; i++) begin
            last_time_next[i] = last_time_reg[i];
        end
        play  = 1'b0;
        sound = LVL_URGENT;

        if (in_data_reg.action == ACT_SNOOZE) begin
            if (active_valid_reg) begin
                snoozed_next[active_index_reg] = 1'b1;
            end
        end else if (!in_data_reg.reading_present || stale) begin
            active_valid_next = 1'b0;
        end else if (!hit_any || !hit_allow) begin
            // Out of every range or outside the windows: clear and drop.
            if (active_valid_reg) begin
                snoozed_next[active_index_reg]   = 1'b0;
                last_time_next[active_index_reg] = '0;
            end
            active_valid_next = 1'b0;
        end else if (!active_valid_reg) begin
            active_valid_next       = 1'b1;
            active_index_next       = hit_lvl;
            last_time_next[hit_lvl] = in_data_reg.now_epoch_seconds;
            snoozed_next[hit_lvl]   = 1'b0;
            play  = 1'b1;
            sound = hit_lvl;
        end else if (snoozed_reg[active_index_reg]) begin
            if (snz_min != 8'd0 && diff > {18'd0, snz_secs}) begin
                snoozed_next[active_index_reg]   = 1'b0;
                last_time_next[active_index_reg] = in_data_reg.now_epoch_seconds;
                play  = 1'b1;
                sound = hit_lvl;
            end
        end else if (diff > {16'd0, interval}) begin
            last_time_next[active_index_reg] = in_data_reg.now_epoch_seconds;
            play  = 1'b1;
            sound = hit_lvl;
        end

        result.play_sound     = play;
        result.sound_level    = sound;
        result.active_level   = active_valid_next ? active_index_next : LVL_NONE;
        result.active_snoozed = active_valid_next && snoozed_next[active_index_next];
    end

    // State registers advance with each processed beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_valid_reg <= 1'b0;
            active_index_reg <= LVL_URGENT;
            snoozed_reg      <= '0;
            for (int i = 0; i < 3; i++) begin
                last_time_reg[i] <= '0;
            end
        end else if (advance) begin
            active_valid_reg <= active_valid_next;
            active_index_reg <= active_index_next;
            snoozed_reg      <= snoozed_next;
            for (int i = 0; i < 3; i++) begin
                last_time_reg[i] <= last_time_next[i];
            end
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= result;
        end
    end

endmodule

`default_nettype wire

### src/gasc_checker.sv
// ----------------------------------------------------------------------------
// gasc_checker
// Port-level checks on the result channel of the glucose alarm controller.
// ----------------------------------------------------------------------------
`default_nettype none

`include "glucose_alarm_snooze_controller_assert.svh"

module gasc_checker
    import gasc_pkg::*;
(
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire out_t m_data
);

    // A stalled result beat holds.
    `GASC_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data), "result beat changed while stalled")

    // A sound only starts with an active, unsnoozed alarm.
    `GASC_ASSERT_NOW(a_play_active, m_valid && m_data.play_sound, m_data.active_level != LVL_NONE && !m_data.active_snoozed, "sound without an active unsnoozed alarm")

    // Without a sound the level field is zero.
    `GASC_ASSERT_NOW(a_quiet_level, m_valid && !m_data.play_sound, m_data.sound_level == LVL_URGENT, "sound level set without a sound")

    // A snooze mark needs an active alarm.
    `GASC_ASSERT_NOW(a_snooze_active, m_valid && m_data.active_snoozed, m_data.active_level != LVL_NONE, "snooze mark without an active alarm")

endmodule

bind glucose_alarm_snooze_controller gasc_checker u_gasc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
